FILE: hw/rtl/brbf_pkg.sv
// Shared types, widths and codes for the byte ring-buffer FIFO.
// Used by every module of the block except brbf_ram; depends on nothing.
package brbf_pkg;

    // Storage depth and derived widths
    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 8;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 2;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PUT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLR    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WBYTE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RBURST = 3'd5;

    // Decoded operations carried through the queue
    localparam logic [REQ_W-1:0] OP_PUT    = 3'd0;
    localparam logic [REQ_W-1:0] OP_GET    = 3'd1;
    localparam logic [REQ_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [REQ_W-1:0] OP_CLR    = 3'd3;
    localparam logic [REQ_W-1:0] OP_WBYTE  = 3'd4;
    localparam logic [REQ_W-1:0] OP_RBURST = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOROOM = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] data_in;
        logic [CNT_W-1:0]  burst_length;
        logic              burst_last;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  moved_count;
        logic              last;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  avail_count;
    } rsp_t;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  len;
        logic              blast;
    } op_t;

    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } ram_ctl_t;

endpackage

FILE: hw/rtl/brbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module brbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/brbf_front.sv
// Front end: accepts request items and classifies them into queue operations.
// Depends on brbf_pkg.
module brbf_front (
    input  logic          req_valid,
    output logic          req_stall,
    input  brbf_pkg::req_t req,
    input  logic          q_full,
    output logic          q_push,
    output brbf_pkg::op_t q_op
);
    import brbf_pkg::*;

    logic known;

    // Stall only while the queue has no room
    assign req_stall = q_full;

    // Map request codes to operations; unused codes are dropped on accept
    always_comb
    begin
        known      = 1'b1;
        q_op.kind  = OP_PUT;
        q_op.data  = req.data_in;
        q_op.len   = req.burst_length;
        q_op.blast = req.burst_last;
        case (req.req_type)
            REQ_PUT:    q_op.kind = OP_PUT;
            REQ_GET:    q_op.kind = OP_GET;
            REQ_PEEK:   q_op.kind = OP_PEEK;
            REQ_CLR:    q_op.kind = OP_CLR;
            REQ_WBYTE:  q_op.kind = OP_WBYTE;
            REQ_RBURST: q_op.kind = OP_RBURST;
            default:    known     = 1'b0;
        endcase
    end

    assign q_push = req_valid && !q_full && known;

endmodule

FILE: hw/rtl/brbf_queue.sv
// Short operation queue that decouples the front end from the back end.
// Depends on brbf_pkg.
module brbf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  brbf_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output brbf_pkg::op_t head_op
);
    import brbf_pkg::*;

    op_t            entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == QCW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: hw/rtl/brbf_back.sv
// Back end: ring pointers, fill count, burst tracking, result and output stages.
// Depends on brbf_pkg; drives the storage RAM through a ram_ctl_t group.
module brbf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [brbf_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic                    op_valid,
    input  brbf_pkg::op_t           op,
    output logic                    op_pop,
    output brbf_pkg::ram_ctl_t      ram_ctl,
    input  logic [brbf_pkg::DATA_W-1:0] ram_rdata,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output brbf_pkg::rsp_t          rsp
);
    import brbf_pkg::*;

    typedef struct packed {
        logic             use_ram;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] moved;
        logic             last;
        logic [CNT_W-1:0] free;
        logic [CNT_W-1:0] avail;
    } desc_t;

    // Ring state
    logic [CNT_W-1:0] size_reg, size_next;
    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             burst_active_reg, burst_active_next;
    logic             burst_admitted_reg, burst_admitted_next;
    logic [CNT_W-1:0] burst_written_reg, burst_written_next;

    // Read-burst sequencer
    logic             rb_active_reg, rb_active_next;
    logic [CNT_W-1:0] rb_left_reg, rb_left_next;
    logic [CNT_W-1:0] rb_moved_reg, rb_moved_next;

    // Result and output stages
    logic             desc_valid_reg, desc_valid_next;
    desc_t            desc_reg, desc_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg;

    logic             out_free, desc_move, desc_free, desc_load;

    // Write-burst and read-burst helpers
    logic [CNT_W-1:0] room;
    logic             wb_adm, wb_store;
    logic [CNT_W-1:0] wb_bw, wb_bwn;
    logic [AW-1:0]    wb_addr, wb_commit;
    logic [CNT_W-1:0] rb_cnt;

    function automatic logic [AW-1:0] wrap(input logic [SUM_W-1:0] s,
                                           input logic [CNT_W-1:0] sz);
        logic [SUM_W-1:0] t;
        if (s >= SUM_W'(sz))
        begin
            t = s - SUM_W'(sz);
        end
        else
        begin
            t = s;
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > CNT_W'(DEPTH))
        begin
            r = CNT_W'(DEPTH);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Stage handshakes
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign desc_move = desc_valid_reg && out_free;
    assign desc_free = !desc_valid_reg || desc_move;

    // Admission and staging for a write-burst byte
    assign room     = size_reg - fill_reg;
    assign wb_adm   = burst_active_reg ? burst_admitted_reg
                                       : ((op.len != '0) && (op.len <= room));
    assign wb_bw    = burst_active_reg ? burst_written_reg : '0;
    assign wb_store = wb_adm && (wb_bw < op.len) && (wb_bw < room);
    assign wb_bwn   = wb_store ? wb_bw + CNT_W'(1) : wb_bw;
    assign wb_addr  = wrap(SUM_W'(wr_idx_reg) + SUM_W'(wb_bw), size_reg);
    assign wb_commit = wrap(SUM_W'(wr_idx_reg) + SUM_W'(wb_bwn), size_reg);

    // Bytes a read burst can deliver
    assign rb_cnt = (op.len < fill_reg) ? op.len : fill_reg;

    // Apply a ring-size write, or execute one operation, or one byte of an open read burst
    always_comb
    begin
        size_next           = size_reg;
        wr_idx_next         = wr_idx_reg;
        rd_idx_next         = rd_idx_reg;
        fill_next           = fill_reg;
        burst_active_next   = burst_active_reg;
        burst_admitted_next = burst_admitted_reg;
        burst_written_next  = burst_written_reg;
        rb_active_next      = rb_active_reg;
        rb_left_next        = rb_left_reg;
        rb_moved_next       = rb_moved_reg;
        op_pop              = 1'b0;
        desc_load           = 1'b0;
        desc_next.use_ram   = 1'b0;
        desc_next.status    = ST_OK;
        desc_next.moved     = '0;
        desc_next.last      = 1'b1;
        ram_ctl.we          = 1'b0;
        ram_ctl.waddr       = wr_idx_reg;
        ram_ctl.wdata       = op.data;
        ram_ctl.re          = 1'b0;
        ram_ctl.raddr       = rd_idx_reg;

        if (cfg_we)
        begin
            // New ring size empties the ring and drops any burst
            size_next           = clamp_size(cfg_wdata);
            wr_idx_next         = '0;
            rd_idx_next         = '0;
            fill_next           = '0;
            burst_active_next   = 1'b0;
            burst_admitted_next = 1'b0;
            burst_written_next  = '0;
            rb_active_next      = 1'b0;
        end
        else if (rb_active_reg)
        begin
            // Emit the next byte of a read burst
            if (desc_free)
            begin
                ram_ctl.re        = 1'b1;
                rd_idx_next       = wrap(SUM_W'(rd_idx_reg) + SUM_W'(1), size_reg);
                rb_left_next      = rb_left_reg - CNT_W'(1);
                rb_moved_next     = rb_moved_reg + CNT_W'(1);
                desc_load         = 1'b1;
                desc_next.use_ram = 1'b1;
                desc_next.moved   = rb_moved_reg + CNT_W'(1);
                desc_next.last    = (rb_left_reg == CNT_W'(1));
                if (rb_left_reg == CNT_W'(1))
                begin
                    rb_active_next = 1'b0;
                end
            end
        end
        else if (op_valid && desc_free)
        begin
            op_pop = 1'b1;
            if (op.kind != OP_WBYTE)
            begin
                burst_active_next   = 1'b0;
                burst_admitted_next = 1'b0;
                burst_written_next  = '0;
            end
            case (op.kind)
                OP_PUT:
                begin
                    desc_load = 1'b1;
                    if (fill_reg >= size_reg)
                    begin
                        desc_next.status = ST_NOROOM;
                    end
                    else
                    begin
                        ram_ctl.we      = 1'b1;
                        wr_idx_next     = wrap(SUM_W'(wr_idx_reg) + SUM_W'(1), size_reg);
                        fill_next       = fill_reg + CNT_W'(1);
                        desc_next.moved = CNT_W'(1);
                    end
                end
                OP_GET, OP_PEEK:
                begin
                    desc_load = 1'b1;
                    if (fill_reg == '0)
                    begin
                        desc_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ram_ctl.re        = 1'b1;
                        desc_next.use_ram = 1'b1;
                        desc_next.moved   = CNT_W'(1);
                        if (op.kind == OP_GET)
                        begin
                            rd_idx_next = wrap(SUM_W'(rd_idx_reg) + SUM_W'(1), size_reg);
                            fill_next   = fill_reg - CNT_W'(1);
                        end
                    end
                end
                OP_CLR:
                begin
                    desc_load   = 1'b1;
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    fill_next   = '0;
                end
                OP_WBYTE:
                begin
                    // Stage the byte past the tail if the burst is admitted
                    ram_ctl.waddr = wb_addr;
                    ram_ctl.we    = wb_store;
                    if (!op.blast)
                    begin
                        burst_active_next   = 1'b1;
                        burst_admitted_next = wb_adm;
                        burst_written_next  = wb_bwn;
                    end
                    else
                    begin
                        desc_load           = 1'b1;
                        burst_active_next   = 1'b0;
                        burst_admitted_next = 1'b0;
                        burst_written_next  = '0;
                        if (wb_adm)
                        begin
                            wr_idx_next     = wb_commit;
                            fill_next       = fill_reg + wb_bwn;
                            desc_next.moved = wb_bwn;
                        end
                        else
                        begin
                            desc_next.status = ST_NOROOM;
                        end
                    end
                end
                OP_RBURST:
                begin
                    desc_load = 1'b1;
                    if (rb_cnt == '0)
                    begin
                        desc_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ram_ctl.re        = 1'b1;
                        rd_idx_next       = wrap(SUM_W'(rd_idx_reg) + SUM_W'(1), size_reg);
                        fill_next         = fill_reg - rb_cnt;
                        desc_next.use_ram = 1'b1;
                        desc_next.moved   = CNT_W'(1);
                        desc_next.last    = (rb_cnt == CNT_W'(1));
                        rb_active_next    = (rb_cnt != CNT_W'(1));
                        rb_left_next      = rb_cnt - CNT_W'(1);
                        rb_moved_next     = CNT_W'(1);
                    end
                end
                default:
                begin
                    desc_load = 1'b0;
                end
            endcase
        end

        // Counts reported after the whole item
        desc_next.free  = size_reg - fill_next;
        desc_next.avail = fill_next;
    end

    // Result stage occupancy
    always_comb
    begin
        desc_valid_next = desc_valid_reg;
        if (desc_load)
        begin
            desc_valid_next = 1'b1;
        end
        else if (desc_move)
        begin
            desc_valid_next = 1'b0;
        end
        rsp_valid_next = rsp_valid_reg;
        if (desc_move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg           <= CNT_W'(DEPTH);
            wr_idx_reg         <= '0;
            rd_idx_reg         <= '0;
            fill_reg           <= '0;
            burst_active_reg   <= 1'b0;
            burst_admitted_reg <= 1'b0;
            burst_written_reg  <= '0;
            rb_active_reg      <= 1'b0;
            rb_left_reg        <= '0;
            rb_moved_reg       <= '0;
            desc_valid_reg     <= 1'b0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            size_reg           <= size_next;
            wr_idx_reg         <= wr_idx_next;
            rd_idx_reg         <= rd_idx_next;
            fill_reg           <= fill_next;
            burst_active_reg   <= burst_active_next;
            burst_admitted_reg <= burst_admitted_next;
            burst_written_reg  <= burst_written_next;
            rb_active_reg      <= rb_active_next;
            rb_left_reg        <= rb_left_next;
            rb_moved_reg       <= rb_moved_next;
            desc_valid_reg     <= desc_valid_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    // Payload: load the result stage, then merge RAM data into the output item
    always_ff @(posedge clk)
    begin
        if (desc_load)
        begin
            desc_reg <= desc_next;
        end
        if (desc_move)
        begin
            rsp_reg.data_out    <= desc_reg.use_ram ? ram_rdata : '0;
            rsp_reg.status      <= desc_reg.status;
            rsp_reg.moved_count <= desc_reg.moved;
            rsp_reg.last        <= desc_reg.last;
            rsp_reg.free_count  <= desc_reg.free;
            rsp_reg.avail_count <= desc_reg.avail;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hw/rtl/byte_ring_buffer_fifo.sv
// Byte ring-buffer FIFO over 64 bytes of storage, of which buffer_size bytes form the
// ring. Request items are taken at up to one per cycle, while the queue has room, into
// a two-item queue; the back end carries out one request per cycle unless the result
// side stalls, except a read burst, which holds the back end until it has delivered
// its min(burst_length, fill) bytes, or its single empty result. When nothing stalls,
// a result is offered once its item has left the queue, been carried out into the
// result stage while the storage read is registered, and moved into the output
// register. Writes to buffer_size must only be made while the block is idle; they
// empty the ring. Depends on brbf_pkg, brbf_front, brbf_queue, brbf_back and brbf_ram.
module byte_ring_buffer_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [brbf_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  brbf_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output brbf_pkg::rsp_t                 rsp
);
    import brbf_pkg::*;

    logic             q_full, q_push, q_pop, q_valid;
    op_t              q_in_op, q_head_op;
    ram_ctl_t         ram_ctl;
    logic [DATA_W-1:0] ram_rdata;

    // Accept and classify
    brbf_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_in_op)
    );

    // Decouple front and back
    brbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_in_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head_op)
    );

    // Execute against the ring
    brbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .op_valid  (q_valid),
        .op        (q_head_op),
        .op_pop    (q_pop),
        .ram_ctl   (ram_ctl),
        .ram_rdata (ram_rdata),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Ring storage
    brbf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_ctl.we),
        .waddr (ram_ctl.waddr),
        .wdata (ram_ctl.wdata),
        .re    (ram_ctl.re),
        .raddr (ram_ctl.raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte ring-buffer FIFO (byte_ring_buffer_fifo).
// Holds its own model of the ring, drives requests with random gaps and stalls.
// Depends on brbf_pkg and the RTL of the block only.
module tb;
    import brbf_pkg::*;

    // Request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

    // Idle cycles to let no-result items clear the pipe, the watchdog limit and requests per size
    localparam int SETTLE      = 12;
    localparam int QUIET_LIMIT = 2000;
    localparam int PER_PHASE   = 55;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    req_t           req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    rsp_t           rsp;

    // Model of the ring
    logic [7:0]     ring_mem [DEPTH];
    logic [6:0]     size_reg;
    int unsigned    wr_ptr, rd_ptr, fill;
    bit             wb_open, wb_ok;
    int unsigned    wb_count;

    rsp_t           due_rsp [$];
    rsp_t           want_rsp;
    int             errors = 0;
    int             items_sent = 0;
    int             rsp_checked = 0;
    int             refusals = 0;
    int             empties = 0;
    int             phases = 0;
    int             quiet_cycles = 0;
    int             hold_left = 0;
    bit             send_calm = 1'b0;
    bit             recv_calm = 1'b0;
    bit             fill_bias = 1'b1;

    byte_ring_buffer_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic req_t rq(logic [REQ_W-1:0] kind, logic [7:0] data,
                                logic [6:0] len, logic blast);
        req_t r;
        r.req_type     = kind;
        r.data_in      = data;
        r.burst_length = len;
        r.burst_last   = blast;
        return r;
    endfunction

    function automatic rsp_t rs(logic [7:0] data, logic [ST_W-1:0] st, int unsigned moved,
                                int unsigned free, int unsigned avail);
        rsp_t e;
        e.data_out    = data;
        e.status      = st;
        e.moved_count = 7'(moved);
        e.last        = 1'b1;
        e.free_count  = 7'(free);
        e.avail_count = 7'(avail);
        return e;
    endfunction

    // Size of the ring in use: zero acts as one, anything above the store as the store
    function automatic int unsigned ring_len();
        if (size_reg == 0)
            return 1;
        if (size_reg > DEPTH)
            return DEPTH;
        return size_reg;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 75)
            return $urandom_range(1, 2);
        if (p < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    task automatic abandon_burst();
        wb_open  = 1'b0;
        wb_ok    = 1'b0;
        wb_count = 0;
    endtask

    task automatic flush_ring();
        wr_ptr = 0;
        rd_ptr = 0;
        fill   = 0;
        abandon_burst();
    endtask

    // Work out the results of one accepted request and queue them
    task automatic fifo_predict(input req_t r);
        int unsigned size, room, len, cnt;
        rsp_t batch [$];
        size = ring_len();
        len  = r.burst_length;
        if (r.req_type > REQ_RBURST)
            return;
        if (r.req_type == REQ_WBYTE)
        begin
            room = size - fill;
            // first byte decides admission of the whole burst
            if (!wb_open)
            begin
                wb_open  = 1'b1;
                wb_ok    = (len != 0) && (len <= room);
                wb_count = 0;
            end
            if (wb_ok && wb_count < len && wb_count < room)
            begin
                ring_mem[(wr_ptr + wb_count) % size] = r.data_in;
                wb_count++;
            end
            if (!r.burst_last)
                return;
            if (wb_ok)
            begin
                wr_ptr = (wr_ptr + wb_count) % size;
                fill += wb_count;
                batch.push_back(rs(8'h00, ST_OK, wb_count, 0, 0));
            end
            else
            begin
                batch.push_back(rs(8'h00, ST_NOROOM, 0, 0, 0));
                refusals++;
            end
            abandon_burst();
        end
        else
        begin
            // any other request drops an open burst silently
            abandon_burst();
            case (r.req_type)
                REQ_PUT:
                    if (fill >= size)
                    begin
                        batch.push_back(rs(8'h00, ST_NOROOM, 0, 0, 0));
                        refusals++;
                    end
                    else
                    begin
                        ring_mem[wr_ptr] = r.data_in;
                        wr_ptr = (wr_ptr + 1) % size;
                        fill++;
                        batch.push_back(rs(8'h00, ST_OK, 1, 0, 0));
                    end
                REQ_GET, REQ_PEEK:
                    if (fill == 0)
                    begin
                        batch.push_back(rs(8'h00, ST_EMPTY, 0, 0, 0));
                        empties++;
                    end
                    else
                    begin
                        batch.push_back(rs(ring_mem[rd_ptr], ST_OK, 1, 0, 0));
                        if (r.req_type == REQ_GET)
                        begin
                            rd_ptr = (rd_ptr + 1) % size;
                            fill--;
                        end
                    end
                REQ_CLR:
                begin
                    flush_ring();
                    batch.push_back(rs(8'h00, ST_OK, 0, 0, 0));
                end
                default:
                begin
                    cnt = (len < fill) ? len : fill;
                    if (cnt == 0)
                    begin
                        batch.push_back(rs(8'h00, ST_EMPTY, 0, 0, 0));
                        empties++;
                    end
                    for (int i = 0; i < cnt; i++)
                    begin
                        batch.push_back(rs(ring_mem[rd_ptr], ST_OK, i + 1, 0, 0));
                        rd_ptr = (rd_ptr + 1) % size;
                        fill--;
                    end
                end
            endcase
        end
        // counts reflect the state after the whole request
        foreach (batch[k])
        begin
            batch[k].free_count  = 7'(size - fill);
            batch[k].avail_count = 7'(fill);
            batch[k].last        = (k == batch.size() - 1);
            due_rsp.push_back(batch[k]);
        end
    endtask

    // Offer one item after a random gap, hold it until taken, then predict
    task automatic send_item(input req_t r, input bit typed = 1'b0, input rsp_t want = '0);
        int unsigned gap;
        gap = (send_calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if ($urandom_range(0, 63) == 0)
            send_calm = !send_calm;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        fifo_predict(r);
        if (typed)
            due_rsp[$] = want;
        if (r.req_type <= REQ_RBURST)
            items_sent++;
        @(negedge clk);
    endtask

    // Change the ring size once everything owed has come back
    task automatic write_ring_size(input logic [6:0] v);
        req_valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        size_reg = v;
        flush_ring();
        phases++;
    endtask

    // One random request, or one whole write burst
    task automatic random_traffic();
        int unsigned pick, room, len, nbytes, k;
        bit cut;
        req_t r;
        room = ring_len() - fill;
        pick = $urandom_range(0, 99);
        r = rq(REQ_PUT, 8'($urandom), 7'($urandom), 1'($urandom));
        if ($urandom_range(0, 23) == 0)
            fill_bias = !fill_bias;
        if (pick < 45)
        begin
            r.req_type = (pick < (fill_bias ? 35 : 10)) ? REQ_PUT : REQ_GET;
            send_item(r);
        end
        else if (pick < 51)
        begin
            r.req_type = REQ_PEEK;
            send_item(r);
        end
        else if (pick < 54)
        begin
            r.req_type = REQ_CLR;
            send_item(r);
        end
        else if (pick < 82)
        begin
            // mostly bursts that fit, some too long, empty or odd
            k = $urandom_range(0, 9);
            if (k < 6)
                len = $urandom_range(1, room > 0 ? room : 1);
            else if (k == 6)
                len = room + 1;
            else if (k == 7)
                len = 0;
            else if (k == 8)
                len = $urandom_range(1, 127);
            else
                len = 64;
            nbytes = (len == 0) ? 1 : len;
            cut = 1'b0;
            k = $urandom_range(0, 9);
            if (k == 7)
                nbytes = $urandom_range(1, nbytes);
            else if (k == 8)
                nbytes = nbytes + $urandom_range(1, 3);
            else if (k == 9)
            begin
                nbytes = $urandom_range(1, nbytes);
                cut = 1'b1;
            end
            if (nbytes > 70)
                nbytes = 70;
            for (int i = 0; i < nbytes; i++)
            begin
                r.req_type     = REQ_WBYTE;
                r.data_in      = 8'($urandom);
                r.burst_length = ($urandom_range(0, 15) == 0) ? 7'($urandom) : 7'(len);
                r.burst_last   = (i == nbytes - 1) && !cut;
                send_item(r);
            end
        end
        else if (pick < 96)
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
                len = $urandom_range(1, fill + 2);
            else if (k == 6)
                len = 0;
            else if (k == 7)
                len = 64;
            else if (k == 8)
                len = $urandom_range(65, 127);
            else
                len = fill;
            r.req_type     = REQ_RBURST;
            r.burst_length = 7'(len);
            send_item(r);
        end
        else
        begin
            r.req_type = pick[0] ? REQ_SPARE7 : REQ_SPARE6;
            send_item(r);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= 40)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     rsp_checked, what, got, want);
    endtask

    // Check each taken result against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_checked++;
            if (due_rsp.size() == 0)
                report_mismatch("result with none owed, data_out", rsp.data_out, 0);
            else
            begin
                want_rsp = due_rsp.pop_front();
                if (rsp.data_out !== want_rsp.data_out)
                    report_mismatch("data_out", rsp.data_out, want_rsp.data_out);
                if (rsp.status !== want_rsp.status)
                    report_mismatch("status", rsp.status, want_rsp.status);
                if (rsp.moved_count !== want_rsp.moved_count)
                    report_mismatch("moved_count", rsp.moved_count, want_rsp.moved_count);
                if (rsp.last !== want_rsp.last)
                    report_mismatch("last", rsp.last, want_rsp.last);
                if (rsp.free_count !== want_rsp.free_count)
                    report_mismatch("free_count", rsp.free_count, want_rsp.free_count);
                if (rsp.avail_count !== want_rsp.avail_count)
                    report_mismatch("avail_count", rsp.avail_count, want_rsp.avail_count);
            end
        end
    end

    // Stall the result side in random stretches, with calm spells
    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            recv_calm = !recv_calm;
        if (hold_left == 0 && !recv_calm && $urandom_range(0, 3) == 0)
            hold_left = gap_len();
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    // Abort when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress, %0d results still owed", due_rsp.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        plan_row_t plan [$];
        logic [6:0] ring_sizes [8];
        int goal;

        size_reg = 7'd64;
        flush_ring();
        ring_sizes = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd5, 7'd33, 7'd64};
        ring_sizes[6] = 7'($urandom_range(3, 63));

        // Directed rows at the reset size of 64
        plan.push_back('{rq(REQ_GET, 8'h00, 7'd0, 1'b0), 1'b1,
                         rs(8'h00, ST_EMPTY, 0, 64, 0)});
        plan.push_back('{rq(REQ_PEEK, 8'hFF, 7'd127, 1'b1), 1'b1,
                         rs(8'h00, ST_EMPTY, 0, 64, 0)});
        plan.push_back('{rq(REQ_RBURST, 8'h00, 7'd5, 1'b0), 1'b1,
                         rs(8'h00, ST_EMPTY, 0, 64, 0)});
        plan.push_back('{rq(REQ_PUT, 8'hFF, 7'd127, 1'b1), 1'b1,
                         rs(8'h00, ST_OK, 1, 63, 1)});
        plan.push_back('{rq(REQ_PUT, 8'h00, 7'd0, 1'b0), 1'b1,
                         rs(8'h00, ST_OK, 1, 62, 2)});
        plan.push_back('{rq(REQ_PEEK, 8'h00, 7'd0, 1'b0), 1'b1, rs(8'hFF, ST_OK, 1, 62, 2)});
        plan.push_back('{rq(REQ_GET, 8'h00, 7'd0, 1'b0), 1'b1, rs(8'hFF, ST_OK, 1, 63, 1)});
        plan.push_back('{rq(REQ_RBURST, 8'h00, 7'd0, 1'b0), 1'b1,
                         rs(8'h00, ST_EMPTY, 0, 63, 1)});
        // burst that fits exactly
        plan.push_back('{rq(REQ_WBYTE, 8'hA5, 7'd3, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_WBYTE, 8'h5A, 7'd3, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_WBYTE, 8'h3C, 7'd3, 1'b1), 1'b1,
                         rs(8'h00, ST_OK, 3, 60, 4)});
        // zero length and too long are refused
        plan.push_back('{rq(REQ_WBYTE, 8'h42, 7'd0, 1'b1), 1'b1,
                         rs(8'h00, ST_NOROOM, 0, 60, 4)});
        plan.push_back('{rq(REQ_WBYTE, 8'h77, 7'd64, 1'b1), 1'b1,
                         rs(8'h00, ST_NOROOM, 0, 60, 4)});
        // short burst commits what came
        plan.push_back('{rq(REQ_WBYTE, 8'h11, 7'd5, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_WBYTE, 8'h22, 7'd5, 1'b1), 1'b0, '0});
        // burst cut off by a put
        plan.push_back('{rq(REQ_WBYTE, 8'h99, 7'd4, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_PUT, 8'h81, 7'd0, 1'b0), 1'b0, '0});
        // bytes past the declared length are ignored
        plan.push_back('{rq(REQ_WBYTE, 8'hC3, 7'd2, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_WBYTE, 8'h3C, 7'd2, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_WBYTE, 8'hE7, 7'd2, 1'b1), 1'b0, '0});
        plan.push_back('{rq(REQ_RBURST, 8'h00, 7'd64, 1'b0), 1'b0, '0});
        // unused codes
        plan.push_back('{rq(REQ_SPARE7, 8'hFF, 7'd127, 1'b1), 1'b0, '0});
        plan.push_back('{rq(REQ_SPARE6, 8'h00, 7'd0, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_PUT, 8'h80, 7'd64, 1'b0), 1'b0, '0});
        plan.push_back('{rq(REQ_CLR, 8'h00, 7'd0, 1'b0), 1'b1,
                         rs(8'h00, ST_OK, 0, 64, 0)});

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
            send_item(plan[i].r, plan[i].typed, plan[i].want);

        // Random traffic over a range of ring sizes
        foreach (ring_sizes[p])
        begin
            write_ring_size(ring_sizes[p]);
            goal = items_sent + PER_PHASE;
            while (items_sent < goal)
                random_traffic();
        end

        // Drain and let the pipe settle
        req_valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("summary: %0d requests over %0d ring sizes, %0d results checked",
                 items_sent, phases, rsp_checked);
        $display("summary: %0d refused writes, %0d empty reads, %0d mismatches",
                 refusals, empties, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
